>>> sv/geo_segment_densify_step_top_assert.svh
// assertion macros for the segment densifier
`ifndef GEO_SEGMENT_DENSIFY_STEP_TOP_ASSERT_SVH
`define GEO_SEGMENT_DENSIFY_STEP_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment densifier assertion failed");

// next-cycle implication, checked out of reset
`define GSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment densifier assertion failed");

`endif

>>> sv/gsd_pkg.sv
// ----------------------------------------------------------------------------
// gsd_pkg
// shared types and constants of the lat/lon segment densifier
// ----------------------------------------------------------------------------
`default_nettype none

package gsd_pkg;

    localparam int unsigned QUO_W = 24;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_PASS = 3'd0;
    localparam t_mode MODE_VERT = 3'd1;
    localparam t_mode MODE_HORZ = 3'd2;
    localparam t_mode MODE_LATS = 3'd3;
    localparam t_mode MODE_LONS = 3'd4;
    localparam t_mode MODE_DIAG = 3'd5;

    localparam logic [0:0] REG_INSERT_ENABLE = 1'b0;

    // tolerance for equal coordinates, in lsb
    localparam logic [32:0] EQUAL_TOL_LSB = 33'd2;

    localparam logic [23:0] STEP14_U  = 24'd11744051;
    localparam logic [32:0] DEG2_U    = 33'd16777216;
    localparam logic [30:0] DEG85_U   = 31'd713031680;
    localparam logic [32:0] DEG180_U  = 33'd1509949440;

    localparam logic signed [33:0] DEG2_S   = 34'sd16777216;
    localparam logic signed [33:0] STEP14_S = 34'sd11744051;
    localparam logic signed [33:0] DEG90_S  = 34'sd754974720;
    localparam logic signed [33:0] DEG180_S = 34'sd1509949440;
    localparam logic signed [33:0] DEG360_S = 34'sd3019898880;

    typedef struct packed {
        logic signed [30:0] plat;
        logic signed [30:0] nlat;
        logic signed [31:0] plon;
        logic signed [31:0] nlon;
        t_mode              mode;
        logic               fwd;
        logic               latup;
        logic               neg;
        logic               red;
    } t_ctx;

endpackage

`default_nettype wire

>>> sv/geo_segment_densify_step_top.sv
// ----------------------------------------------------------------------------
// geo_segment_densify_step_top
// one step of a lat/lon segment densifier: emits the candidate vertex or an
// intermediate point on long segments, with date line wrap and saturation
// ----------------------------------------------------------------------------
// channel   direction  handshake                       payload
// input     in         i_in_valid / o_in_ready         prev/next lat and lon
// output    out        o_out_valid / i_out_ready       out lat/lon, inserted, redundant
// config    in         psel, penable, pwrite, pready   insert_enable at address 0
//
// one transaction per cycle sustained while the output is not stalled; the pipeline is
// the 24-stage quotient pipeline plus nine arithmetic stages
// reset is synchronous and clears all valid bits and insert_enable
// each stage loads when empty or when the next stage moves, so bubbles close up
// and a stalled output holds its transaction without loss
`default_nettype none

module geo_segment_densify_step_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [30:0] i_prev_lat,
    input  wire logic signed [31:0] i_prev_lon,
    input  wire logic signed [30:0] i_next_lat,
    input  wire logic signed [31:0] i_next_lon,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [30:0]      o_out_lat,
    output logic signed [31:0]      o_out_lon,
    output logic                    o_inserted,
    output logic                    o_redundant,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // configuration
    logic r_insert_enable;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_insert_enable <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == gsd_pkg::REG_INSERT_ENABLE)) begin
            r_insert_enable <= pwdata[0];
        end
    end

    always_comb begin
        if (paddr[2] == gsd_pkg::REG_INSERT_ENABLE) begin
            prdata = {31'd0, r_insert_enable};
        end else begin
            prdata = '0;
        end
    end

    // ready chain
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6, w_rdy7, w_rdy8, w_rdy_out;
    logic w_div_ready;

    // stage 1: differences
    logic                r1_v;
    logic signed [30:0]  r1_plat, r1_nlat;
    logic signed [31:0]  r1_plon, r1_nlon;
    logic signed [31:0]  r1_dlat;
    logic signed [32:0]  r1_dlon;
    logic signed [31:0]  w_dlat;
    logic signed [32:0]  w_dlon;

    assign w_dlat = 32'(i_next_lat) - 32'(i_prev_lat);
    assign w_dlon = 33'(i_next_lon) - 33'(i_prev_lon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_rdy1) begin
            r1_v <= i_in_valid;
        end
        if (w_rdy1 && i_in_valid) begin
            r1_plat <= i_prev_lat;
            r1_nlat <= i_next_lat;
            r1_plon <= i_prev_lon;
            r1_nlon <= i_next_lon;
            r1_dlat <= w_dlat;
            r1_dlon <= w_dlon;
        end
    end

    // stage 2: magnitudes, polar test, direction signs
    logic                r2_v;
    logic signed [30:0]  r2_plat, r2_nlat;
    logic signed [31:0]  r2_plon, r2_nlon;
    logic [31:0]         r2_adlat;
    logic [32:0]         r2_adlon;
    logic                r2_pole, r2_dlat_pos, r2_dlat_neg, r2_dlon_pos, r2_dlon_neg;
    logic [31:0]         w_adlat;
    logic [32:0]         w_adlon;
    logic [30:0]         w_anlat, w_aplat;

    always_comb begin
        w_adlat = r1_dlat[31] ? 32'(-r1_dlat) : 32'(r1_dlat);
        w_adlon = r1_dlon[32] ? 33'(-r1_dlon) : 33'(r1_dlon);
        w_anlat = r1_nlat[30] ? 31'(-r1_nlat) : 31'(r1_nlat);
        w_aplat = r1_plat[30] ? 31'(-r1_plat) : 31'(r1_plat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_rdy2) begin
            r2_v <= r1_v;
        end
        if (w_rdy2 && r1_v) begin
            r2_plat     <= r1_plat;
            r2_nlat     <= r1_nlat;
            r2_plon     <= r1_plon;
            r2_nlon     <= r1_nlon;
            r2_adlat    <= w_adlat;
            r2_adlon    <= w_adlon;
            r2_pole     <= (w_anlat > gsd_pkg::DEG85_U) && (w_aplat > gsd_pkg::DEG85_U);
            r2_dlat_neg <= r1_dlat[31];
            r2_dlat_pos <= !r1_dlat[31] && (r1_dlat != '0);
            r2_dlon_neg <= r1_dlon[32];
            r2_dlon_pos <= !r1_dlon[32] && (r1_dlon != '0);
        end
    end

    // stage 3: line class flags and slope products
    logic                r3_v;
    logic signed [30:0]  r3_plat, r3_nlat;
    logic signed [31:0]  r3_plon, r3_nlon;
    logic [31:0]         r3_adlat;
    logic [32:0]         r3_adlon;
    logic                r3_ins, r3_vert, r3_horz, r3_red, r3_fwd, r3_latup, r3_neg;
    logic [42:0]         r3_m1000, r3_m999, r3_m1001;
    logic                w_short, w_ins, w_vert, w_horz;

    always_comb begin
        w_short = ({1'b0, r2_adlat} <= gsd_pkg::DEG2_U) && (r2_adlon <= gsd_pkg::DEG2_U);
        w_ins   = r_insert_enable && !w_short && !r2_pole;
        w_vert  = r2_adlon < gsd_pkg::EQUAL_TOL_LSB;
        w_horz  = {1'b0, r2_adlat} < gsd_pkg::EQUAL_TOL_LSB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_rdy3) begin
            r3_v <= r2_v;
        end
        if (w_rdy3 && r2_v) begin
            r3_plat  <= r2_plat;
            r3_nlat  <= r2_nlat;
            r3_plon  <= r2_plon;
            r3_nlon  <= r2_nlon;
            r3_adlat <= r2_adlat;
            r3_adlon <= r2_adlon;
            r3_ins   <= w_ins;
            r3_vert  <= w_vert;
            r3_horz  <= w_horz;
            r3_red   <= !w_ins && w_vert && w_horz;
            r3_fwd   <= r2_dlon_pos ^ (r2_adlon > gsd_pkg::DEG180_U);
            r3_latup <= r2_dlat_pos;
            r3_neg   <= r2_dlat_neg ^ r2_dlon_neg;
            r3_m1000 <= 43'(r2_adlat) * 43'd1000;
            r3_m999  <= 43'(r2_adlon) * 43'd999;
            r3_m1001 <= 43'(r2_adlon) * 43'd1001;
        end
    end

    // stage 4: mode decision, divider operand select
    logic                r4_v;
    gsd_pkg::t_ctx       r4_ctx;
    logic [32:0]         r4_a, r4_d;
    gsd_pkg::t_mode      w_mode;
    gsd_pkg::t_ctx       w_ctx4;

    always_comb begin
        priority if (!r3_ins) begin
            w_mode = gsd_pkg::MODE_PASS;
        end else if (r3_vert) begin
            w_mode = gsd_pkg::MODE_VERT;
        end else if (r3_horz) begin
            w_mode = gsd_pkg::MODE_HORZ;
        end else if (r3_m1000 < r3_m999) begin
            w_mode = gsd_pkg::MODE_LATS;
        end else if (r3_m1000 > r3_m1001) begin
            w_mode = gsd_pkg::MODE_LONS;
        end else begin
            w_mode = gsd_pkg::MODE_DIAG;
        end
        w_ctx4.plat  = r3_plat;
        w_ctx4.nlat  = r3_nlat;
        w_ctx4.plon  = r3_plon;
        w_ctx4.nlon  = r3_nlon;
        w_ctx4.mode  = w_mode;
        w_ctx4.fwd   = r3_fwd;
        w_ctx4.latup = r3_latup;
        w_ctx4.neg   = r3_neg;
        w_ctx4.red   = r3_red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_rdy4) begin
            r4_v <= r3_v;
        end
        if (w_rdy4 && r3_v) begin
            r4_ctx <= w_ctx4;
            // latitude-dominant lines scale longitude, else the other way
            if (w_mode == gsd_pkg::MODE_LONS) begin
                r4_a <= r3_adlon;
                r4_d <= {1'b0, r3_adlat};
            end else begin
                r4_a <= {1'b0, r3_adlat};
                r4_d <= r3_adlon;
            end
        end
    end

    // stage 5: scale by the 1.4 degree step
    logic                r5_v;
    gsd_pkg::t_ctx       r5_ctx;
    logic [56:0]         r5_prod;
    logic [32:0]         r5_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_rdy5) begin
            r5_v <= r4_v;
        end
        if (w_rdy5 && r4_v) begin
            r5_ctx  <= r4_ctx;
            r5_prod <= 57'(r4_a) * 57'(gsd_pkg::STEP14_U);
            r5_d    <= r4_d;
        end
    end

    // stage 6: rounding bias and initial partial remainder
    logic                r6_v;
    gsd_pkg::t_ctx       r6_ctx;
    logic [32:0]         r6_rem;
    logic [23:0]         r6_low;
    logic [32:0]         r6_d;
    logic [57:0]         w_nr;

    assign w_nr = 58'(r5_prod) + 58'(r5_d >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_rdy6) begin
            r6_v <= r5_v;
        end
        if (w_rdy6 && r5_v) begin
            r6_ctx <= r5_ctx;
            r6_rem <= w_nr[56:24];
            r6_low <= w_nr[23:0];
            r6_d   <= r5_d;
        end
    end

    // quotient pipeline
    logic                w_div_v;
    gsd_pkg::t_ctx       w_div_ctx;
    logic [23:0]         w_div_quo;

    gsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_v),
        .o_ready (w_div_ready),
        .i_ctx   (r6_ctx),
        .i_rem   (r6_rem),
        .i_low   (r6_low),
        .i_den   (r6_d),
        .o_valid (w_div_v),
        .i_ready (w_rdy7),
        .o_ctx   (w_div_ctx),
        .o_quo   (w_div_quo)
    );

    // stage 7: raw output point
    logic                r7_v;
    logic signed [33:0]  r7_lat, r7_lon;
    logic                r7_wrap, r7_ins, r7_red;
    logic signed [33:0]  w_plat, w_plon, w_q, w_qs, w_lat_d2, w_lat_s14, w_lon_d2, w_lon_s14;
    logic signed [33:0]  w_lat7, w_lon7;

    always_comb begin
        w_plat    = 34'(w_div_ctx.plat);
        w_plon    = 34'(w_div_ctx.plon);
        w_q       = $signed({10'd0, w_div_quo});
        w_qs      = w_div_ctx.neg ? -w_q : w_q;
        w_lat_d2  = w_div_ctx.latup ? w_plat + gsd_pkg::DEG2_S : w_plat - gsd_pkg::DEG2_S;
        w_lat_s14 = w_div_ctx.latup ? w_plat + gsd_pkg::STEP14_S : w_plat - gsd_pkg::STEP14_S;
        w_lon_d2  = w_div_ctx.fwd ? w_plon + gsd_pkg::DEG2_S : w_plon - gsd_pkg::DEG2_S;
        w_lon_s14 = w_div_ctx.fwd ? w_plon + gsd_pkg::STEP14_S : w_plon - gsd_pkg::STEP14_S;
        unique case (w_div_ctx.mode)
            gsd_pkg::MODE_VERT: begin
                w_lat7 = w_lat_d2;
                w_lon7 = w_plon;
            end
            gsd_pkg::MODE_HORZ: begin
                w_lat7 = 34'(w_div_ctx.nlat);
                w_lon7 = w_lon_d2;
            end
            gsd_pkg::MODE_LATS: begin
                w_lat7 = w_plat + w_qs;
                w_lon7 = w_lon_s14;
            end
            gsd_pkg::MODE_LONS: begin
                w_lat7 = w_lat_s14;
                w_lon7 = w_plon + w_qs;
            end
            gsd_pkg::MODE_DIAG: begin
                w_lat7 = w_lat_s14;
                w_lon7 = w_lon_s14;
            end
            default: begin
                w_lat7 = 34'(w_div_ctx.nlat);
                w_lon7 = 34'(w_div_ctx.nlon);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_rdy7) begin
            r7_v <= w_div_v;
        end
        if (w_rdy7 && w_div_v) begin
            r7_lat  <= w_lat7;
            r7_lon  <= w_lon7;
            r7_wrap <= (w_div_ctx.mode != gsd_pkg::MODE_PASS) &&
                       (w_div_ctx.mode != gsd_pkg::MODE_VERT);
            r7_ins  <= (w_div_ctx.mode != gsd_pkg::MODE_PASS);
            r7_red  <= w_div_ctx.red;
        end
    end

    // stage 8: date line wrap
    logic                r8_v;
    logic signed [33:0]  r8_lat, r8_lon;
    logic                r8_ins, r8_red;
    logic signed [33:0]  w_lon8;

    always_comb begin
        priority if (r7_wrap && (r7_lon > gsd_pkg::DEG180_S)) begin
            w_lon8 = r7_lon - gsd_pkg::DEG360_S;
        end else if (r7_wrap && (r7_lon < -gsd_pkg::DEG180_S)) begin
            w_lon8 = r7_lon + gsd_pkg::DEG360_S;
        end else begin
            w_lon8 = r7_lon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_rdy8) begin
            r8_v <= r7_v;
        end
        if (w_rdy8 && r7_v) begin
            r8_lat <= r7_lat;
            r8_lon <= w_lon8;
            r8_ins <= r7_ins;
            r8_red <= r7_red;
        end
    end

    // output register: saturation
    logic                r_ov;
    logic signed [30:0]  r_olat;
    logic signed [31:0]  r_olon;
    logic                r_oins, r_ored;
    logic signed [33:0]  w_lat_c, w_lon_c;

    always_comb begin
        priority if (r8_lat > gsd_pkg::DEG90_S) begin
            w_lat_c = gsd_pkg::DEG90_S;
        end else if (r8_lat < -gsd_pkg::DEG90_S) begin
            w_lat_c = -gsd_pkg::DEG90_S;
        end else begin
            w_lat_c = r8_lat;
        end
        priority if (r8_lon > gsd_pkg::DEG180_S) begin
            w_lon_c = gsd_pkg::DEG180_S;
        end else if (r8_lon < -gsd_pkg::DEG180_S) begin
            w_lon_c = -gsd_pkg::DEG180_S;
        end else begin
            w_lon_c = r8_lon;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy_out) begin
            r_ov <= r8_v;
        end
        if (w_rdy_out && r8_v) begin
            r_olat <= w_lat_c[30:0];
            r_olon <= w_lon_c[31:0];
            r_oins <= r8_ins;
            r_ored <= r8_red;
        end
    end

    assign w_rdy_out = !r_ov || i_out_ready;
    assign w_rdy8    = !r8_v || w_rdy_out;
    assign w_rdy7    = !r7_v || w_rdy8;
    assign w_rdy6    = !r6_v || w_div_ready;
    assign w_rdy5    = !r5_v || w_rdy6;
    assign w_rdy4    = !r4_v || w_rdy5;
    assign w_rdy3    = !r3_v || w_rdy4;
    assign w_rdy2    = !r2_v || w_rdy3;
    assign w_rdy1    = !r1_v || w_rdy2;

    assign o_in_ready  = w_rdy1;
    assign o_out_valid = r_ov;
    assign o_out_lat   = r_olat;
    assign o_out_lon   = r_olon;
    assign o_inserted  = r_oins;
    assign o_redundant = r_ored;

    `include "geo_segment_densify_step_top_assert.svh"

    `GSD_ASSERT_SAME(a_ins_excl_red, o_out_valid, !(o_inserted && o_redundant))
    `GSD_ASSERT_SAME(a_lat_range, o_out_valid, (o_out_lat <= 31'sd754974720) && (o_out_lat >= -31'sd754974720))
    `GSD_ASSERT_NEXT(a_out_load, r8_v && w_rdy_out, o_out_valid)

endmodule

`default_nettype wire

>>> sv/gsd_div.sv
// ----------------------------------------------------------------------------
// gsd_div
// pipelined restoring divider, one quotient bit per stage, with side context
// ----------------------------------------------------------------------------
`default_nettype none

module gsd_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire gsd_pkg::t_ctx              i_ctx,
    input  wire logic [32:0]                i_rem,
    input  wire logic [gsd_pkg::QUO_W-1:0]  i_low,
    input  wire logic [32:0]                i_den,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output gsd_pkg::t_ctx                   o_ctx,
    output logic [gsd_pkg::QUO_W-1:0]       o_quo
);

    localparam int unsigned NS = gsd_pkg::QUO_W;

    logic                r_v   [NS];
    gsd_pkg::t_ctx       r_ctx [NS];
    logic [32:0]         r_rem [NS];
    logic [NS-1:0]       r_low [NS];
    logic [32:0]         r_den [NS];
    logic [NS-1:0]       r_quo [NS];
    logic                w_rdy [NS];

    genvar k;
    for (k = 0; k < NS; k++) begin : g_stage
        logic          s_v;
        gsd_pkg::t_ctx s_ctx;
        logic [32:0]   s_rem;
        logic [NS-1:0] s_low;
        logic [32:0]   s_den;
        logic [NS-1:0] s_quo;
        logic          s_nxt;
        logic [33:0]   s_trial;
        logic [33:0]   s_diff;
        logic          s_ge;
        logic [32:0]   n_rem;
        logic [NS-1:0] n_quo;

        if (k == 0) begin : g_first
            assign s_v   = i_valid;
            assign s_ctx = i_ctx;
            assign s_rem = i_rem;
            assign s_low = i_low;
            assign s_den = i_den;
            assign s_quo = '0;
        end else begin : g_next
            assign s_v   = r_v[k-1];
            assign s_ctx = r_ctx[k-1];
            assign s_rem = r_rem[k-1];
            assign s_low = r_low[k-1];
            assign s_den = r_den[k-1];
            assign s_quo = r_quo[k-1];
        end

        if (k == NS - 1) begin : g_last
            assign s_nxt = i_ready;
        end else begin : g_mid
            assign s_nxt = w_rdy[k+1];
        end

        assign w_rdy[k] = !r_v[k] || s_nxt;

        always_comb begin
            s_trial = {s_rem, s_low[NS-1]};
            s_diff  = s_trial - {1'b0, s_den};
            s_ge    = (s_trial >= {1'b0, s_den});
            n_rem   = s_ge ? s_diff[32:0] : s_trial[32:0];
            n_quo   = {s_quo[NS-2:0], s_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= s_v;
            end
            if (w_rdy[k] && s_v) begin
                r_ctx[k] <= s_ctx;
                r_rem[k] <= n_rem;
                r_low[k] <= {s_low[NS-2:0], 1'b0};
                r_den[k] <= s_den;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_ctx   = r_ctx[NS-1];
    assign o_quo   = r_quo[NS-1];

endmodule

`default_nettype wire

>>> sim/tb_geo_segment_densify_step_top.sv
// ----------------------------------------------------------------------------
// tb_geo_segment_densify_step_top
// self-checking bench for the segment densifier: directed vertex pairs, then
// random pairs across several insert_enable settings and flow-control phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_geo_segment_densify_step_top;

    localparam longint LSB_DEG2   = 64'd16777216;
    localparam longint LSB_STEP14 = 64'd11744051;
    localparam longint LSB_DEG85  = 64'd713031680;
    localparam longint LSB_DEG90  = 64'd754974720;
    localparam longint LSB_DEG180 = 64'd1509949440;
    localparam longint LSB_DEG360 = 64'd3019898880;
    localparam longint TOL_LSB    = 64'd2;
    localparam int     PIPE_LAT   = 33;
    localparam int     CYCLE_LIMIT = 1000000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct packed {
        logic signed [30:0] lat;
        logic signed [31:0] lon;
        logic               ins;
        logic               red;
    } t_vertex_out;

    typedef struct {
        logic signed [30:0] plat;
        logic signed [31:0] plon;
        logic signed [30:0] nlat;
        logic signed [31:0] nlon;
        logic               en;
        logic               has_exp;
        t_vertex_out        exp_out;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [30:0] i_prev_lat;
    logic signed [31:0] i_prev_lon;
    logic signed [30:0] i_next_lat;
    logic signed [31:0] i_next_lon;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [30:0] o_out_lat;
    logic signed [31:0] o_out_lon;
    logic o_inserted;
    logic o_redundant;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    geo_segment_densify_step_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_prev_lat(i_prev_lat), .i_prev_lon(i_prev_lon),
        .i_next_lat(i_next_lat), .i_next_lon(i_next_lon),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_lat(o_out_lat), .o_out_lon(o_out_lon),
        .o_inserted(o_inserted), .o_redundant(o_redundant),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_vertex_out emit_q[$];
    logic        insert_en;
    t_idle       idle_mode;
    int          fail_cnt;
    int          cycle_cnt;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat64(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // rounded to nearest, ties away from zero
    function automatic longint div_near(longint num, longint den);
        longint q;
        q = (abs64(num) + abs64(den) / 2) / abs64(den);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic t_vertex_out densify_step(logic en, logic signed [30:0] pa,
                                                 logic signed [31:0] po,
                                                 logic signed [30:0] na,
                                                 logic signed [31:0] no);
        longint plat, plon, nlat, nlon, dlat, dlon, adlat, adlon, olat, olon;
        logic ins, fwd;
        t_vertex_out r;
        plat = pa; plon = po; nlat = na; nlon = no;
        dlat = nlat - plat; dlon = nlon - plon;
        adlat = abs64(dlat); adlon = abs64(dlon);
        olat = nlat; olon = nlon; ins = 1'b0;
        if (en && !(adlat <= LSB_DEG2 && adlon <= LSB_DEG2) &&
            !(abs64(nlat) > LSB_DEG85 && abs64(plat) > LSB_DEG85)) begin
            ins = 1'b1;
            if (adlon < TOL_LSB) begin
                olat = (nlat > plat) ? plat + LSB_DEG2 : plat - LSB_DEG2;
                olon = plon;
            end else begin
                fwd = nlon > plon;
                if (adlon > LSB_DEG180) fwd = !fwd;
                if (adlat < TOL_LSB) begin
                    olat = nlat;
                    olon = fwd ? plon + LSB_DEG2 : plon - LSB_DEG2;
                end else if (1000 * adlat < 999 * adlon) begin
                    olon = fwd ? plon + LSB_STEP14 : plon - LSB_STEP14;
                    olat = plat + div_near(dlat * LSB_STEP14, dlon);
                end else if (1000 * adlat > 1001 * adlon) begin
                    olat = (nlat > plat) ? plat + LSB_STEP14 : plat - LSB_STEP14;
                    olon = plon + div_near(LSB_STEP14 * dlon, dlat);
                end else begin
                    olon = fwd ? plon + LSB_STEP14 : plon - LSB_STEP14;
                    olat = (nlat > plat) ? plat + LSB_STEP14 : plat - LSB_STEP14;
                end
                if (olon > LSB_DEG180) olon -= LSB_DEG360;
                if (olon < -LSB_DEG180) olon += LSB_DEG360;
            end
        end
        r.red = !ins && adlat < TOL_LSB && adlon < TOL_LSB;
        r.ins = ins;
        r.lat = 31'(sat64(olat, LSB_DEG90));
        r.lon = 32'(sat64(olon, LSB_DEG180));
        return r;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus long forced hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            i_out_ready <= ($urandom_range(99) >= 80);
        end else if (idle_mode == IDLE_BOTH) begin
            i_out_ready <= ($urandom_range(99) >= 6);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_vertex_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (emit_q.size() == 0) begin
                $display("%0t: unexpected transaction lat=%0d lon=%0d", $time,
                         o_out_lat, o_out_lon);
                fail_cnt++;
            end else begin
                e = emit_q.pop_front();
                if (o_out_lat !== e.lat) begin
                    $display("%0t: out_lat exp %0d got %0d", $time, e.lat, o_out_lat);
                    fail_cnt++;
                end
                if (o_out_lon !== e.lon) begin
                    $display("%0t: out_lon exp %0d got %0d", $time, e.lon, o_out_lon);
                    fail_cnt++;
                end
                if (o_inserted !== e.ins) begin
                    $display("%0t: inserted exp %0b got %0b", $time, e.ins, o_inserted);
                    fail_cnt++;
                end
                if (o_redundant !== e.red) begin
                    $display("%0t: redundant exp %0b got %0b", $time, e.red, o_redundant);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic write_enable(logic val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {gsd_pkg::REG_INSERT_ENABLE, 2'b00}; pwdata <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        insert_en = val;
    endtask

    task automatic send_pair(logic signed [30:0] pa, logic signed [31:0] po,
                             logic signed [30:0] na, logic signed [31:0] no,
                             logic has_exp, t_vertex_out exp_out);
        t_vertex_out p;
        if ((idle_mode == IDLE_SEND && $urandom_range(99) < 80) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 6)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_prev_lat <= pa; i_prev_lon <= po; i_next_lat <= na; i_next_lon <= no;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        p = densify_step(insert_en, pa, po, na, no);
        if (has_exp && p !== exp_out) begin
            $display("%0t: table row exp %0d/%0d/%0b/%0b predictor %0d/%0d/%0b/%0b",
                     $time, exp_out.lat, exp_out.lon, exp_out.ins, exp_out.red,
                     p.lat, p.lon, p.ins, p.red);
            fail_cnt++;
        end
        emit_q.push_back(has_exp ? exp_out : p);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (emit_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    function automatic longint rnd_coord(longint lim);
        longint v;
        case ($urandom_range(9))
            0: v = lim;
            1: v = -lim;
            2: v = $urandom_range(3);
            // raw bit patterns: out-of-range values too
            3: v = $signed({$urandom(), $urandom()});
            default: v = longint'($urandom_range(2 * lim)) - lim;
        endcase
        return v;
    endfunction

    // next vertex near or far from the previous one
    task automatic random_pair;
        longint pa, po, na, no;
        t_vertex_out none;
        none = '0;
        pa = rnd_coord(LSB_DEG90);
        po = rnd_coord(LSB_DEG180);
        case ($urandom_range(5))
            0: begin na = pa + $urandom_range(3) - 1; no = po + $urandom_range(3) - 1; end
            1: begin na = pa + $signed($urandom()) / 32; no = po + $urandom_range(2) - 1; end
            2: begin na = pa + $urandom_range(2) - 1; no = po + $signed($urandom()) / 16; end
            3: begin
                na = pa + $signed($urandom()) / 64;
                no = po + ($urandom_range(1) ? (na - pa) : (pa - na)) + $urandom_range(200) - 100;
            end
            default: begin na = rnd_coord(LSB_DEG90); no = rnd_coord(LSB_DEG180); end
        endcase
        send_pair(pa[30:0], po[31:0], na[30:0], no[31:0], 1'b0, none);
    endtask

    t_row dir_tab[$];

    task automatic add_row(logic en, longint pa, longint po, longint na, longint no,
                           logic has_exp, longint ea, longint eo, logic ei, logic er);
        t_row r;
        r.en = en; r.plat = 31'(pa); r.plon = 32'(po); r.nlat = 31'(na); r.nlon = 32'(no);
        r.has_exp = has_exp;
        r.exp_out.lat = 31'(ea); r.exp_out.lon = 32'(eo);
        r.exp_out.ins = ei; r.exp_out.red = er;
        dir_tab.push_back(r);
    endtask

    initial begin
        logic cur_en;
        int n;
        fail_cnt = 0; cycle_cnt = 0; hold_cycles = 0; insert_en = 1'b0;
        idle_mode = IDLE_NONE;
        i_rst_n = 1'b0; i_in_valid = 1'b0;
        i_prev_lat = '0; i_prev_lon = '0; i_next_lat = '0; i_next_lon = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;

        // after reset insertion is off: candidate passes through
        add_row(0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(0, 0, 0, 500000000, 1000000000, 1, 500000000, 1000000000, 0, 0);
        add_row(0, 0, 0, 800000000, -1600000000, 1, LSB_DEG90, -LSB_DEG180, 0, 0);
        add_row(0, -1073741824, -2147483648, 1073741823, 2147483647, 1,
                LSB_DEG90, LSB_DEG180, 0, 0);
        // insertion enabled
        add_row(1, 0, 0, 100000000, 1, 1, LSB_DEG2, 0, 1, 0);
        add_row(1, 0, 0, -100000000, 0, 1, -LSB_DEG2, 0, 1, 0);
        add_row(1, 0, 0, 0, 100000000, 1, 0, LSB_DEG2, 1, 0);
        add_row(1, 0, 0, 1, -100000000, 1, 1, -LSB_DEG2, 1, 0);
        add_row(1, 0, 0, 100000000, 100000000, 1, LSB_STEP14, LSB_STEP14, 1, 0);
        add_row(1, 0, 0, LSB_DEG2, LSB_DEG2, 1, LSB_DEG2, LSB_DEG2, 0, 0);
        add_row(1, 0, 0, 1, 1, 1, 1, 1, 0, 1);
        add_row(1, 720000000, 0, 740000000, 300000000, 1, 740000000, 300000000, 0, 0);
        add_row(1, -720000000, 0, -740000000, 300000000, 1, -740000000, 300000000, 0, 0);
        // date line crossings
        add_row(1, 0, 1500000000, 0, -1500000000, 1, 0, 1500000000 + LSB_DEG2 - LSB_DEG360, 1, 0);
        add_row(1, 0, -1500000000, 0, 1500000000, 1, 0, -1500000000 - LSB_DEG2 + LSB_DEG360, 1, 0);
        add_row(1, 10, 1500000000, 300000000, 1000000000, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 50000000, 200000000, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, -200000000, 50000000, 0, 0, 0, 0, 0);
        add_row(1, LSB_DEG90, LSB_DEG180, -LSB_DEG90, -LSB_DEG180, 0, 0, 0, 0, 0);
        add_row(1, -1073741824, -2147483648, 1073741823, 2147483647, 0, 0, 0, 0, 0);
        // short step near the pole passes the candidate through
        add_row(1, 754000000, 0, 754974720, 1, 1, LSB_DEG90, 1, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_en = 1'b0;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].en != cur_en) begin
                drain();
                write_enable(dir_tab[k].en);
                cur_en = dir_tab[k].en;
            end
            send_pair(dir_tab[k].plat, dir_tab[k].plon, dir_tab[k].nlat, dir_tab[k].nlon,
                      dir_tab[k].has_exp, dir_tab[k].exp_out);
        end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_enable((ph % 4) != 3);
            idle_mode = t_idle'(ph % 4);
            if (ph == 1) hold_cycles <= 200;
            n = 90 + $urandom_range(10);
            for (int k = 0; k < n; k++) begin
                random_pair();
                // sender waits for the pipeline to empty once
                if (ph == 2 && k == 40) begin
                    i_in_valid <= 1'b0;
                    while (emit_q.size() != 0) @(posedge i_clk);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (emit_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
